/* rtl/core/sei_pkg.sv */
`timescale 1ns / 1ps

package sei_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int TBL_AW      = $clog2(TABLE_DEPTH);

	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int S_TDATA_W   = 120;
	localparam int M_TDATA_W   = 56;

	localparam logic [7:0]  MAX_SPEED_RST  = 8'd120;
	localparam logic [7:0]  SPEED_STEP_RST = 8'd10;
	localparam logic [15:0] PCE_FACTOR_RST = 16'd256;

	localparam int SDIV_STEPS_A = 5;
	localparam int SDIV_STEPS_B = 4;
	localparam int IDIV_STEPS   = 8;
	localparam int IDIV_STAGES  = 4;
	localparam int PDIV_STEPS   = 8;
	localparam int PDIV_STAGES  = 6;

	typedef enum logic [1:0] {
		CFG_MAX_SPEED  = 2'd0,
		CFG_SPEED_STEP = 2'd1,
		CFG_PCE_FACTOR = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_COMPUTE = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_INDEX = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] rem;
		logic [8:0] num;
		logic [8:0] quo;
	} sdiv_t;

	typedef struct packed {
		logic [7:0]  rem;
		logic [31:0] num;
	} idiv_t;

	typedef struct packed {
		logic [15:0] rem;
		logic [47:0] num;
	} pdiv_t;

	function automatic sdiv_t sdiv_step(sdiv_t x, logic [7:0] dv);
		logic [8:0] t;
		sdiv_t y;
		t = {x.rem, x.num[8]};
		y.num = {x.num[7:0], 1'b0};
		if (t >= {1'b0, dv}) begin
			y.rem = 8'(t - {1'b0, dv});
			y.quo = {x.quo[7:0], 1'b1};
		end else begin
			y.rem = t[7:0];
			y.quo = {x.quo[7:0], 1'b0};
		end
		return y;
	endfunction

	function automatic idiv_t idiv_step(idiv_t x, logic [7:0] dv);
		logic [8:0] t;
		idiv_t y;
		t = {x.rem, x.num[31]};
		if (t >= {1'b0, dv}) begin
			y.rem = 8'(t - {1'b0, dv});
			y.num = {x.num[30:0], 1'b1};
		end else begin
			y.rem = t[7:0];
			y.num = {x.num[30:0], 1'b0};
		end
		return y;
	endfunction

	function automatic pdiv_t pdiv_step(pdiv_t x, logic [15:0] dv);
		logic [16:0] t;
		pdiv_t y;
		t = {x.rem, x.num[47]};
		if (t >= {1'b0, dv}) begin
			y.rem = 16'(t - {1'b0, dv});
			y.num = {x.num[46:0], 1'b1};
		end else begin
			y.rem = t[15:0];
			y.num = {x.num[46:0], 1'b0};
		end
		return y;
	endfunction

endpackage

/* rtl/core/sei_ram.sv */
`timescale 1ns / 1ps

module sei_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

/* rtl/core/speed_emission_interpolator.sv */
`timescale 1ns / 1ps

// Emission per link from a table of factors at speed breakpoints.
// The slave stream carries one transaction per item: tuser is the opcode, a load
// writes a table entry and a compute interpolates the factor for the link speed
// and scales it by volume and length over the PCE divisor.
// The master stream returns exactly one transaction per item, in order, with the
// emission and a status code.
// The pipeline has 19 register stages and takes one item in every cycle while the
// output is not stalled. The speed division, the interpolation division and the
// PCE division are split over the stages, a few quotient bits per stage, and set
// that depth.
// The configuration port writes a register at any clock edge with cfg_we high;
// the user must write it only while no transaction is in flight; nothing checks it.
// Reset clears the pipeline and loads the default register values. Table
// entries hold no value until a load writes them.
// When the receiver holds m_tready low with a result waiting, the whole
// pipeline holds and s_tready falls, so nothing is lost or repeated.

module speed_emission_interpolator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sei_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sei_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// entry_index, entry_factor, link_speed, traffic_volume, link_length, zero pad
	input  logic [sei_pkg::S_TDATA_W-1:0]    s_tdata,
	// opcode
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// emission, status, zero pad
	output logic [sei_pkg::M_TDATA_W-1:0]    m_tdata
);

	typedef struct packed {
		logic                          valid;
		sei_pkg::opcode_t              op;
		logic [5:0]                    idx;
		logic [31:0]                   factor;
		logic [15:0]                   speed;
		logic [31:0]                   vol;
		logic [31:0]                   len;
		sei_pkg::sdiv_t                kd;
		sei_pkg::sdiv_t                nd;
	} s1_t;

	typedef struct packed {
		logic                          valid;
		sei_pkg::opcode_t              op;
		logic [5:0]                    idx;
		logic [31:0]                   factor;
		logic [15:0]                   speed;
		logic [31:0]                   vol;
		logic [31:0]                   len;
		logic [7:0]                    k;
		logic [7:0]                    rk;
		logic [7:0]                    n;
	} s2_t;

	typedef struct packed {
		logic                          valid;
		logic                          zero;
		sei_pkg::status_t              status;
		logic [15:0]                   d;
		logic [31:0]                   vol;
		logic [31:0]                   len;
	} s3_t;

	typedef struct packed {
		logic                          valid;
		logic                          zero;
		sei_pkg::status_t              status;
		logic [31:0]                   a;
		logic                          up;
		sei_pkg::idiv_t                dv;
		logic [31:0]                   vol;
		logic [31:0]                   len;
	} idv_st_t;

	typedef struct packed {
		logic                          valid;
		sei_pkg::status_t              status;
		logic [31:0]                   f;
		logic [31:0]                   vol;
		logic [31:0]                   len;
	} s9_t;

	typedef struct packed {
		logic                          valid;
		sei_pkg::status_t              status;
		logic [63:0]                   p1;
		logic [31:0]                   len;
	} s10_t;

	typedef struct packed {
		logic                          valid;
		sei_pkg::status_t              status;
		logic [63:0]                   lo;
		logic [63:0]                   hi;
	} s11_t;

	typedef struct packed {
		logic                          valid;
		sei_pkg::status_t              status;
		logic                          ovf;
		sei_pkg::pdiv_t                dv;
	} pdv_st_t;

	typedef struct packed {
		logic                          valid;
		logic [47:0]                   emission;
		sei_pkg::status_t              status;
	} res_t;

	logic [7:0]  max_speed_q;
	logic [7:0]  speed_step_q;
	logic [15:0] pce_factor_q;
	logic [7:0]  stp_eff;
	logic [15:0] pce_eff;
	logic        en;

	s1_t     s1_d, s1_s1;
	s2_t     s2_d, s2_s2;
	s3_t     s3_d, s3_s3;
	idv_st_t s4_d;
	idv_st_t idv_s [0:sei_pkg::IDIV_STAGES];
	idv_st_t idv_nx [0:sei_pkg::IDIV_STAGES-1];
	s9_t     s9_d, s9_s9;
	s10_t    s10_d, s10_s10;
	s11_t    s11_d, s11_s11;
	pdv_st_t s12_d;
	pdv_st_t pdv_s [0:sei_pkg::PDIV_STAGES];
	pdv_st_t pdv_nx [0:sei_pkg::PDIV_STAGES-1];
	res_t    res_d, res_s19;

	logic                        ram_we;
	logic [sei_pkg::TBL_AW-1:0]  ram_raddr_a;
	logic [sei_pkg::TBL_AW-1:0]  ram_raddr_b;
	logic [31:0]                 ram_rdata_a;
	logic [31:0]                 ram_rdata_b;

	assign stp_eff  = (speed_step_q == 8'd0) ? 8'd1 : speed_step_q;
	assign pce_eff  = (pce_factor_q == 16'd0) ? 16'd1 : pce_factor_q;
	assign en       = !res_s19.valid || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q  <= sei_pkg::MAX_SPEED_RST;
			speed_step_q <= sei_pkg::SPEED_STEP_RST;
			pce_factor_q <= sei_pkg::PCE_FACTOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sei_pkg::CFG_MAX_SPEED:  max_speed_q  <= cfg_wdata[7:0];
				sei_pkg::CFG_SPEED_STEP: speed_step_q <= cfg_wdata[7:0];
				sei_pkg::CFG_PCE_FACTOR: pce_factor_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		s1_d.valid  = s_tvalid;
		s1_d.op     = sei_pkg::opcode_t'(s_tuser);
		s1_d.idx    = s_tdata[5:0];
		s1_d.factor = s_tdata[37:6];
		s1_d.speed  = s_tdata[53:38];
		s1_d.vol    = s_tdata[85:54];
		s1_d.len    = s_tdata[117:86];
		s1_d.kd     = '{rem: 8'd0, num: {1'b0, s_tdata[53:46]}, quo: 9'd0};
		s1_d.nd     = '{rem: 8'd0, num: {1'b0, max_speed_q} + {1'b0, stp_eff} - 9'd1,
			quo: 9'd0};
		for (int i = 0; i < sei_pkg::SDIV_STEPS_A; i++) begin
			s1_d.kd = sei_pkg::sdiv_step(s1_d.kd, stp_eff);
			s1_d.nd = sei_pkg::sdiv_step(s1_d.nd, stp_eff);
		end
	end

	always_comb begin
		sei_pkg::sdiv_t kd;
		sei_pkg::sdiv_t nd;
		kd = s1_s1.kd;
		nd = s1_s1.nd;
		for (int i = 0; i < sei_pkg::SDIV_STEPS_B; i++) begin
			kd = sei_pkg::sdiv_step(kd, stp_eff);
			nd = sei_pkg::sdiv_step(nd, stp_eff);
		end
		s2_d.valid  = s1_s1.valid;
		s2_d.op     = s1_s1.op;
		s2_d.idx    = s1_s1.idx;
		s2_d.factor = s1_s1.factor;
		s2_d.speed  = s1_s1.speed;
		s2_d.vol    = s1_s1.vol;
		s2_d.len    = s1_s1.len;
		s2_d.k      = kd.quo[7:0];
		s2_d.rk     = kd.rem;
		s2_d.n      = nd.quo[7:0];
	end

	always_comb begin
		logic [15:0] top;
		logic [15:0] d;
		logic [8:0]  addr;
		logic [8:0]  last;
		top  = {max_speed_q, 8'd0};
		d    = {s2_s2.rk, s2_s2.speed[7:0]};
		addr = {1'b0, s2_s2.k};
		last = {1'b0, s2_s2.k};
		s3_d.valid  = s2_s2.valid;
		s3_d.vol    = s2_s2.vol;
		s3_d.len    = s2_s2.len;
		s3_d.d      = 16'd0;
		s3_d.status = sei_pkg::ST_OK;
		if (s2_s2.op == sei_pkg::OP_LOAD) begin
			if ({3'd0, s2_s2.idx} >= 9'(sei_pkg::TABLE_DEPTH) ||
				{3'd0, s2_s2.idx} > {1'b0, s2_s2.n}) begin
				s3_d.status = sei_pkg::ST_INDEX;
			end
		end else begin
			priority if (s2_s2.speed > top) begin
				s3_d.status = sei_pkg::ST_RANGE;
			end else if (s2_s2.speed == top) begin
				addr = {1'b0, s2_s2.n};
				last = {1'b0, s2_s2.n};
			end else if (d == 16'd0) begin
				addr = {1'b0, s2_s2.k};
			end else begin
				last   = {1'b0, s2_s2.k} + 9'd1;
				s3_d.d = d;
			end
			if (last >= 9'(sei_pkg::TABLE_DEPTH)) begin
				s3_d.status = sei_pkg::ST_RANGE;
			end
		end
		s3_d.zero   = (s2_s2.op == sei_pkg::OP_LOAD) || (s3_d.status != sei_pkg::ST_OK);
		ram_we      = en && s2_s2.valid && (s2_s2.op == sei_pkg::OP_LOAD) &&
			(s3_d.status == sei_pkg::ST_OK);
		ram_raddr_a = addr[sei_pkg::TBL_AW-1:0];
		ram_raddr_b = addr[sei_pkg::TBL_AW-1:0] + sei_pkg::TBL_AW'(1);
	end

	sei_ram #(
		.WIDTH(32),
		.DEPTH(sei_pkg::TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (s2_s2.idx[sei_pkg::TBL_AW-1:0]),
		.wdata   (s2_s2.factor),
		.re      (en),
		.raddr_a (ram_raddr_a),
		.raddr_b (ram_raddr_b),
		.rdata_a (ram_rdata_a),
		.rdata_b (ram_rdata_b)
	);

	always_comb begin
		logic [31:0] diff;
		logic [47:0] prod;
		s4_d.up = ram_rdata_b > ram_rdata_a;
		diff    = s4_d.up ? (ram_rdata_b - ram_rdata_a) : (ram_rdata_a - ram_rdata_b);
		prod    = {16'd0, diff} * {32'd0, s3_s3.d};
		s4_d.valid  = s3_s3.valid;
		s4_d.zero   = s3_s3.zero;
		s4_d.status = s3_s3.status;
		s4_d.a      = ram_rdata_a;
		s4_d.dv     = '{rem: prod[47:40], num: prod[39:8]};
		s4_d.vol    = s3_s3.vol;
		s4_d.len    = s3_s3.len;
	end

	always_comb begin
		for (int i = 0; i < sei_pkg::IDIV_STAGES; i++) begin
			idv_nx[i] = idv_s[i];
			for (int j = 0; j < sei_pkg::IDIV_STEPS; j++) begin
				idv_nx[i].dv = sei_pkg::idiv_step(idv_nx[i].dv, stp_eff);
			end
		end
	end

	always_comb begin
		idv_st_t x;
		x = idv_s[sei_pkg::IDIV_STAGES];
		s9_d.valid  = x.valid;
		s9_d.status = x.status;
		s9_d.vol    = x.vol;
		s9_d.len    = x.len;
		if (x.zero) begin
			s9_d.f = 32'd0;
		end else if (x.up) begin
			s9_d.f = x.a + x.dv.num;
		end else begin
			s9_d.f = x.a - x.dv.num;
		end
	end

	always_comb begin
		s10_d.valid  = s9_s9.valid;
		s10_d.status = s9_s9.status;
		s10_d.p1     = 64'(s9_s9.f) * 64'(s9_s9.vol);
		s10_d.len    = s9_s9.len;
	end

	always_comb begin
		s11_d.valid  = s10_s10.valid;
		s11_d.status = s10_s10.status;
		s11_d.lo     = 64'(s10_s10.p1[31:0]) * 64'(s10_s10.len);
		s11_d.hi     = 64'(s10_s10.p1[63:32]) * 64'(s10_s10.len);
	end

	always_comb begin
		logic [95:0] p;
		p = {s11_s11.hi, 32'd0} + {32'd0, s11_s11.lo};
		s12_d.valid  = s11_s11.valid;
		s12_d.status = s11_s11.status;
		s12_d.ovf    = p[95:64] >= {16'd0, pce_eff};
		s12_d.dv     = '{rem: s12_d.ovf ? 16'd0 : p[79:64], num: p[63:16]};
	end

	always_comb begin
		for (int i = 0; i < sei_pkg::PDIV_STAGES; i++) begin
			pdv_nx[i] = pdv_s[i];
			for (int j = 0; j < sei_pkg::PDIV_STEPS; j++) begin
				pdv_nx[i].dv = sei_pkg::pdiv_step(pdv_nx[i].dv, pce_eff);
			end
		end
	end

	always_comb begin
		pdv_st_t x;
		x = pdv_s[sei_pkg::PDIV_STAGES];
		res_d.valid    = x.valid;
		res_d.status   = x.status;
		res_d.emission = x.ovf ? '1 : x.dv.num;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_s1   <= '0;
			s2_s2   <= '0;
			s3_s3   <= '0;
			s9_s9   <= '0;
			s10_s10 <= '0;
			s11_s11 <= '0;
			res_s19 <= '0;
			for (int i = 0; i <= sei_pkg::IDIV_STAGES; i++) begin
				idv_s[i] <= '0;
			end
			for (int i = 0; i <= sei_pkg::PDIV_STAGES; i++) begin
				pdv_s[i] <= '0;
			end
		end else if (en) begin
			s1_s1    <= s1_d;
			s2_s2    <= s2_d;
			s3_s3    <= s3_d;
			idv_s[0] <= s4_d;
			for (int i = 0; i < sei_pkg::IDIV_STAGES; i++) begin
				idv_s[i+1] <= idv_nx[i];
			end
			s9_s9    <= s9_d;
			s10_s10  <= s10_d;
			s11_s11  <= s11_d;
			pdv_s[0] <= s12_d;
			for (int i = 0; i < sei_pkg::PDIV_STAGES; i++) begin
				pdv_s[i+1] <= pdv_nx[i];
			end
			res_s19  <= res_d;
		end
	end

	assign m_tvalid = res_s19.valid;
	assign m_tdata  = {6'd0, res_s19.status, res_s19.emission};

endmodule
